>>> src/wrrcs_pkg.sv
package wrrcs_pkg;

   // Field widths of the item channels.
   localparam int MASK_W   = 8;
   localparam int PRIO_W   = 16;
   localparam int SLOT_W   = 3;

   // Credit storage.
   localparam int CREDIT_W  = 4;
   localparam int MAX_SLOTS = 64;
   localparam int ADDR_W    = 6;

   // One write into the credit store.
   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [CREDIT_W-1:0] data;
   } credit_wr_type;

   // Refill weight of a priority; the top code behaves like priority 2.
   function automatic logic [CREDIT_W-1:0] weight_of(input logic [1:0] prio);
      logic [CREDIT_W-1:0] w;
      case (prio)
         2'd0:    w = CREDIT_W'(1);
         2'd1:    w = CREDIT_W'(3);
         default: w = CREDIT_W'(9);
      endcase
      return w;
   endfunction

endpackage

>>> src/wrrcs_ram.sv
module wrrcs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/wrrcs_credit_bank.sv
module wrrcs_credit_bank
   import wrrcs_pkg::*;
#(
   parameter int SLOTS = 8,
   localparam int IW   = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  credit_wr_type       wr,
   input  logic [IW-1:0]       rd_addr,
   input  logic [IW-1:0]       chk_addr,
   output logic [CREDIT_W-1:0] credit
);

   // Entries that were never written since reset read as zero credit.
   logic [SLOTS-1:0]    valid_ff;
   logic [SLOTS-1:0]    valid_in;
   logic [CREDIT_W-1:0] rd_data;

   wrrcs_ram #(
      .WIDTH (CREDIT_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr[IW-1:0]),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr[IW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign credit = valid_ff[chk_addr] ? rd_data : '0;

endmodule

>>> src/weighted_round_robin_credit_scheduler_core.sv
// Weighted round-robin credit scheduler, evaluated once per timer tick.
//
// Input channel (req_*): one item per tick carries the live mask, the ready mask
// and two priority bits per slot. The block raises req_stall from the cycle after
// it takes an item until that item's result has been handed to the output register.
// Result channel (rsp_*): one item per input item with the granted slot, the idle
// flag and a flag that tells whether credits were refilled during this tick.
// Timing: a single sequencer walks the credit memory one slot per cycle, reading
// one entry and checking the entry read in the cycle before. A tick runs a search
// pass that stops at the first hit; after a miss, a refill pass visits every slot
// and writes the weight of each live one, a second search pass follows, and the
// result is then loaded into the output register. The single memory read port
// sets this pace.
// Reset clears the credit valid bits at once, so every credit reads as zero and the
// last granted slot is slot zero; no clearing pass is needed.
// When the receiver stalls, the result stays in the output register; the block still
// takes and works on the next item and holds its result until the register is free.
module weighted_round_robin_credit_scheduler_core
   import wrrcs_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MASK_W-1:0] req_live_mask,
   input  logic [MASK_W-1:0] req_ready_mask,
   input  logic [PRIO_W-1:0] req_priority_vector,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SLOT_W-1:0] rsp_chosen_slot,
   output logic              rsp_run_idle,
   output logic              rsp_new_round
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REFILL,
      S_PUSH
   } state_type;

   // Advance a slot index circularly.
   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      return (p == IW'(SLOTS - 1)) ? '0 : p + IW'(1);
   endfunction

   state_type             state_ff, state_in;

   // Latched tick inputs, widened to the slot count. Slots beyond the mask
   // width are never live and have priority zero.
   logic [SLOTS-1:0]      live_ff, live_in;
   logic [SLOTS-1:0]      elig_ff, elig_in;
   logic [2*SLOTS-1:0]    prio_ff, prio_in;

   logic [IW-1:0]         last_ff, last_in;
   logic [IW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IW-1:0]         chk_idx_ff, chk_idx_in;
   logic                  refilled_ff, refilled_in;

   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  res_idle_ff, res_idle_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_idle_ff, rsp_idle_in;
   logic                  rsp_round_ff, rsp_round_in;

   logic [MAX_SLOTS-1:0]   live_wide;
   logic [MAX_SLOTS-1:0]   ready_wide;
   logic [2*MAX_SLOTS-1:0] prio_wide;
   logic [ADDR_W-1:0]      chk_wide;

   credit_wr_type         credit_wr;
   logic [CREDIT_W-1:0]   credit;
   logic                  accept;
   logic                  hit;
   logic                  pass_done;
   logic                  out_free;

   assign live_wide  = MAX_SLOTS'(req_live_mask);
   assign ready_wide = MAX_SLOTS'(req_ready_mask);
   assign prio_wide  = (2*MAX_SLOTS)'(req_priority_vector);
   assign chk_wide   = ADDR_W'(chk_idx_ff);

   wrrcs_credit_bank #(
      .SLOTS (SLOTS)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .wr       (credit_wr),
      .rd_addr  (ptr_ff),
      .chk_addr (chk_idx_ff),
      .credit   (credit)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // The check stage looks at the entry read in the cycle before. A pass is over
   // once every slot has been read and the last one has been checked.
   assign hit       = (state_ff == S_SCAN) && chk_vld_ff && elig_ff[chk_idx_ff]
                      && (credit != '0);
   assign pass_done = !chk_vld_ff && (cnt_ff == CW'(SLOTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      elig_in      = elig_ff;
      prio_in      = prio_ff;
      last_in      = last_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      refilled_in  = refilled_ff;
      res_slot_in  = res_slot_ff;
      res_idle_in  = res_idle_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in  = rsp_slot_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_round_in = rsp_round_ff;
      credit_wr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               live_in     = live_wide[SLOTS-1:0];
               elig_in     = live_wide[SLOTS-1:0] & ready_wide[SLOTS-1:0];
               prio_in     = prio_wide[2*SLOTS-1:0];
               ptr_in      = wrap_inc(last_ff);
               cnt_in      = '0;
               refilled_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               // Grant: spend one credit and remember the slot for the next tick.
               credit_wr.en   = 1'b1;
               credit_wr.addr = chk_wide;
               credit_wr.data = credit - CREDIT_W'(1);
               last_in        = chk_idx_ff;
               res_slot_in    = chk_wide[SLOT_W-1:0];
               res_idle_in    = 1'b0;
               state_in       = S_PUSH;
            end else if (pass_done) begin
               if (!refilled_ff) begin
                  ptr_in   = '0;
                  state_in = S_REFILL;
               end else begin
                  res_slot_in = '0;
                  res_idle_in = 1'b1;
                  state_in    = S_PUSH;
               end
            end else if (cnt_ff != CW'(SLOTS)) begin
               // Issue the read of the slot at the pointer.
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff;
               ptr_in     = wrap_inc(ptr_ff);
               cnt_in     = cnt_ff + CW'(1);
            end
         end
         S_REFILL: begin
            credit_wr.en   = live_ff[ptr_ff];
            credit_wr.addr = ADDR_W'(ptr_ff);
            credit_wr.data = weight_of(prio_ff[2*ptr_ff +: 2]);
            if (ptr_ff == IW'(SLOTS - 1)) begin
               ptr_in      = wrap_inc(last_ff);
               cnt_in      = '0;
               refilled_in = 1'b1;
               state_in    = S_SCAN;
            end else begin
               ptr_in = wrap_inc(ptr_ff);
            end
         end
         S_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_idle_in  = res_idle_ff;
               rsp_round_in = refilled_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      live_ff      <= live_in;
      elig_ff      <= elig_in;
      prio_ff      <= prio_in;
      ptr_ff       <= ptr_in;
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      refilled_ff  <= refilled_in;
      res_slot_ff  <= res_slot_in;
      res_idle_ff  <= res_idle_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_idle_ff  <= rsp_idle_in;
      rsp_round_ff <= rsp_round_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_run_idle    = rsp_idle_ff;
   assign rsp_new_round   = rsp_round_ff;

   // The idle task only runs after a refill pass has also found nothing.
   a_idle_after_refill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_idle |-> rsp_new_round)
      else $error("idle result without a refill");

   // An idle result always reports slot zero.
   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_idle |-> rsp_chosen_slot == '0)
      else $error("idle result with a nonzero slot");

   // A grant only goes to a live slot.
   a_grant_live: assert property (@(posedge clock) disable iff (reset)
      hit |-> live_ff[chk_idx_ff])
      else $error("grant to a slot that is not live");

   // A taken item always starts with a search pass.
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_SCAN)
      else $error("accepted item did not start a search");

endmodule

>>> dv/tb_weighted_round_robin_credit_scheduler_core.sv
`timescale 1ns / 100ps

module tb_weighted_round_robin_credit_scheduler_core;
   import wrrcs_pkg::*;

   localparam int SLOTS        = 8;
   localparam int RANDOM_TICKS = 700;

   // Credits loaded into a live slot at the start of a round, by priority.
   // The top priority code earns the same weight as priority two.
   localparam logic [CREDIT_W-1:0] REFILL_WEIGHT [4] = '{4'd1, 4'd3, 4'd9, 4'd9};

   // One timer tick as offered on the input channel. A tick marked
   // hold_for_drain is not offered until every earlier grant has come back.
   typedef struct {
      logic [MASK_W-1:0] live;
      logic [MASK_W-1:0] ready;
      logic [PRIO_W-1:0] prio;
      bit                hold_for_drain;
   } tick_type;

   // The scheduling decision that one tick produces.
   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              idle;
      logic              refilled;
   } grant_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [MASK_W-1:0] req_live_mask = '0;
   logic [MASK_W-1:0] req_ready_mask = '0;
   logic [PRIO_W-1:0] req_priority_vector = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [SLOT_W-1:0] rsp_chosen_slot;
   logic              rsp_run_idle;
   logic              rsp_new_round;

   // Scheduler state as the block should hold it. Reset is applied once, so
   // the reset values are simply the initial values.
   logic [CREDIT_W-1:0] credit_left [SLOTS] = '{default: '0};
   logic [SLOT_W-1:0]   last_slot = '0;

   tick_type    pending_ticks [$];
   grant_type   expected_grants [$];
   int unsigned total_ticks = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_hold = 0;

   weighted_round_robin_credit_scheduler_core #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_live_mask      (req_live_mask),
      .req_ready_mask     (req_ready_mask),
      .req_priority_vector(req_priority_vector),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_chosen_slot    (rsp_chosen_slot),
      .rsp_run_idle       (rsp_run_idle),
      .rsp_new_round      (rsp_new_round)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Idle lengths for both channels. A calm window with no idling at all recurs,
   // so back-to-back traffic is covered too.
   // Outside it, most gaps are short and a few are long.
   function automatic int unsigned draw_gap();
      int unsigned r;
      if ((cycle_count % 1500) < 300) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Circular search that starts just after the last granted slot. Returns
   // the first live, ready slot with credit left, or -1 when none qualifies.
   function automatic int find_eligible(input logic [MASK_W-1:0] live,
                                        input logic [MASK_W-1:0] ready);
      int idx;
      for (int off = 1; off <= SLOTS; off++) begin
         idx = (int'(last_slot) + off) % SLOTS;
         if (live[idx] && ready[idx] && credit_left[idx] != '0) begin
            return idx;
         end
      end
      return -1;
   endfunction

   // Works out the grant of one tick and advances the scheduler state. When
   // the first search fails, every live slot is reloaded to its weight and
   // the search runs again; a second miss means the idle task runs, which
   // reports slot zero and leaves the last granted slot alone.
   function automatic grant_type predict_grant(input logic [MASK_W-1:0] live,
                                               input logic [MASK_W-1:0] ready,
                                               input logic [PRIO_W-1:0] prio);
      grant_type g;
      int        hit;
      g   = '{slot: '0, idle: 1'b0, refilled: 1'b0};
      hit = find_eligible(live, ready);
      if (hit < 0) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
               credit_left[i] = REFILL_WEIGHT[prio[2*i +: 2]];
            end
         end
         g.refilled = 1'b1;
         hit = find_eligible(live, ready);
      end
      if (hit < 0) begin
         g.idle = 1'b1;
      end else begin
         credit_left[hit] = credit_left[hit] - 1'b1;
         last_slot        = SLOT_W'(hit);
         g.slot           = SLOT_W'(hit);
      end
      return g;
   endfunction

   function automatic void add_tick(input logic [MASK_W-1:0] live,
                                    input logic [MASK_W-1:0] ready,
                                    input logic [PRIO_W-1:0] prio,
                                    input bit                hold);
      tick_type t;
      t = '{live: live, ready: ready, prio: prio, hold_for_drain: hold};
      pending_ticks.push_back(t);
   endfunction

   // Driver. The expected grant is computed at the edge where the tick is
   // taken, so the prediction sees ticks in exactly the order the block does.
   // req_valid gets a single nonblocking write per edge, which keeps it high
   // across back-to-back ticks.
   always @(posedge clock) begin
      tick_type nxt;
      logic     valid_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         valid_next = req_valid;
         if (req_valid && !req_stall) begin
            expected_grants.push_back(predict_grant(req_live_mask, req_ready_mask,
                                                    req_priority_vector));
            accepted_count++;
            valid_next = 1'b0;
            send_gap   = draw_gap();
         end
         if (!valid_next) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_ticks.size() != 0 &&
                         !(pending_ticks[0].hold_for_drain &&
                           checked_count != accepted_count)) begin
               nxt = pending_ticks.pop_front();
               req_live_mask       <= nxt.live;
               req_ready_mask      <= nxt.ready;
               req_priority_vector <= nxt.prio;
               valid_next = 1'b1;
            end
         end
         req_valid <= valid_next;
      end
   end

   // Monitor. Every grant taken off the result channel is checked against the
   // oldest prediction. The stall pattern alternates random stretches of
   // stall and flow so that stalls land on every phase of the search.
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count <= checked_count + 1;
            if (expected_grants.size() == 0) begin
               $error("unexpected grant: chosen_slot %0d run_idle %0b new_round %0b",
                      rsp_chosen_slot, rsp_run_idle, rsp_new_round);
               failures++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_chosen_slot !== want.slot) begin
                  $error("chosen_slot: expected %0d, actual %0d", want.slot, rsp_chosen_slot);
                  failures++;
               end
               if (rsp_run_idle !== want.idle) begin
                  $error("run_idle: expected %0b, actual %0b", want.idle, rsp_run_idle);
                  failures++;
               end
               if (rsp_new_round !== want.refilled) begin
                  $error("new_round: expected %0b, actual %0b", want.refilled, rsp_new_round);
                  failures++;
               end
            end
         end
         if (stall_hold != 0) begin
            stall_hold--;
         end else if ($urandom_range(99) < 35) begin
            rsp_stall  <= 1'b1;
            stall_hold = draw_gap();
         end else begin
            rsp_stall  <= 1'b0;
            stall_hold = $urandom_range(0, 6);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [MASK_W-1:0] set_live;
      logic [MASK_W-1:0] ready;
      logic [PRIO_W-1:0] set_prio;
      int unsigned       n;
      int unsigned       run_len;
      int unsigned       r;

      // Directed ticks. Nothing live at all, and ready slots that are not
      // live: both must end in the idle task with a refill flagged.
      add_tick(8'h00, 8'h00, 16'h0000, 1'b0);
      add_tick(8'h00, 8'hFF, 16'hFFFF, 1'b0);
      // Everything live and ready at the lowest and highest priority codes.
      add_tick(8'hFF, 8'hFF, 16'h0000, 1'b0);
      add_tick(8'hFF, 8'hFF, 16'hFFFF, 1'b0);
      // Live but nothing ready: credits refill but the idle task runs.
      add_tick(8'hFF, 8'h00, 16'hAAAA, 1'b0);
      // Live and ready sets that do not overlap.
      add_tick(8'h55, 8'hAA, 16'h5555, 1'b0);
      add_tick(8'h0F, 8'hF0, 16'hFFFF, 1'b0);
      // One slot alone at priority one, on four ticks in a row.
      for (int k = 0; k < 4; k++) begin
         add_tick(8'h01, 8'h01, 16'h0001, 1'b0);
      end
      // Walk a single live, ready slot across every position.
      for (int i = 0; i < SLOTS; i++) begin
         add_tick(MASK_W'(1) << i, MASK_W'(1) << i, PRIO_W'($urandom()), 1'b0);
      end
      // Slot seven at the top priority code, then every slot ready again.
      add_tick(8'h80, 8'h80, 16'hC000, 1'b0);
      add_tick(8'hFF, 8'hFF, 16'h1B1B, 1'b0);

      // Random ticks. Most come in runs with a fixed process set and
      // priorities, so credits drain over many ticks and rounds roll over;
      // the rest are unrelated noise. The first random tick and one halfway
      // through wait for the block to drain completely.
      n = 0;
      while (n < RANDOM_TICKS) begin
         r = $urandom_range(99);
         if (r < 15) begin
            add_tick(MASK_W'($urandom()), MASK_W'($urandom()), PRIO_W'($urandom()),
                     n == 0 || n == RANDOM_TICKS / 2);
            n++;
         end else begin
            set_live = ($urandom_range(9) == 0) ? 8'hFF : MASK_W'($urandom_range(1, 255));
            case ($urandom_range(4))
               0:       set_prio = 16'h0000;
               1:       set_prio = 16'hFFFF;
               2:       set_prio = 16'h5555;
               default: set_prio = PRIO_W'($urandom());
            endcase
            run_len = $urandom_range(8, 40);
            for (int k = 0; k < run_len && n < RANDOM_TICKS; k++) begin
               r = $urandom_range(99);
               // Processes are mostly ready; sometimes a few block.
               ready = set_live & (MASK_W'($urandom()) | MASK_W'($urandom()));
               if (r < 10) begin
                  ready = ready | MASK_W'($urandom());
               end else if (r < 15) begin
                  set_live = set_live ^ (MASK_W'(1) << $urandom_range(0, SLOTS - 1));
               end
               add_tick(set_live, ready, set_prio, n == 0 || n == RANDOM_TICKS / 2);
               n++;
            end
         end
      end
      total_ticks = pending_ticks.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (checked_count != total_ticks) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $error("%0d expected grants never arrived", expected_grants.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest legal run.
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
src/wrrcs_pkg.sv
src/wrrcs_ram.sv
src/wrrcs_credit_bank.sv
src/weighted_round_robin_credit_scheduler_core.sv
dv/tb_weighted_round_robin_credit_scheduler_core.sv
